@@ src/atte_pkg.sv @@
// Shared types and constants for the ANSI text terminal engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package atte_pkg;

    localparam int ATTE_MAX_COLS  = 128;
    localparam int ATTE_MAX_ROWS  = 64;
    localparam int CMD_FIFO_DEPTH = 2;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET = 7'd25;

    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_RIGHT  = 8'h43;
    localparam logic [7:0] CH_LEFT   = 8'h44;
    localparam logic [7:0] CH_HOME   = 8'h48;
    localparam logic [7:0] CH_ED     = 8'h4A;
    localparam logic [7:0] CH_NB     = 8'h62;
    localparam logic [7:0] CH_SGR    = 8'h6D;
    localparam logic [7:0] CH_RAW    = 8'h72;
    localparam logic [7:0] CH_NOSCR  = 8'h73;

    localparam logic [15:0] PARAM_MAX = 16'hFFFF;
    localparam logic [15:0] FG_BASE   = 16'd30;
    localparam logic [15:0] BG_BASE   = 16'd40;
    localparam logic [15:0] ED_ALL    = 16'd2;
    localparam logic [15:0] PAL_LAST  = 16'd7;

    localparam logic [23:0] FG_RESET = 24'hAAAAAA;
    localparam logic [23:0] BG_RESET = 24'h000000;

    localparam logic [23:0] PALETTE [8] = '{
        24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
        24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA
    };

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PRINT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_UP,
        OP_DOWN,
        OP_RIGHT,
        OP_LEFT,
        OP_HOME,
        OP_SGR,
        OP_ED,
        OP_TOG_RAW,
        OP_TOG_NB,
        OP_TOG_SCROLL
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  ch;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
    } cmd_t;

endpackage

`default_nettype wire

@@ src/atte_front.sv @@
// Front end: accepts bytes, runs the escape-sequence parser, emits one command per byte.
// Depends on atte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atte_front
    import atte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_in,
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_cmd
);

    logic        esc_reg, esc_next;
    logic [15:0] p1_reg, p1_next;
    logic [15:0] p2_reg, p2_next;
    logic        second_reg, second_next;
    logic        def1_reg, def1_next;
    logic        def2_reg, def2_next;

    logic [15:0] sel_param;
    logic [19:0] acc;
    logic [15:0] acc_sat;
    logic [15:0] move_v;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    assign sel_param = second_reg ? p2_reg : p1_reg;
    assign acc       = {1'b0, sel_param, 3'b000} + {3'b000, sel_param, 1'b0}
                     + 20'(byte_in - CH_ZERO);
    assign acc_sat   = (acc[19:16] != 4'd0) ? PARAM_MAX : acc[15:0];
    assign move_v    = def1_reg ? 16'd1 : p1_reg;

    always_comb
    begin
        esc_next    = esc_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        second_next = second_reg;
        def1_next   = def1_reg;
        def2_next   = def2_reg;
        q_cmd.op    = OP_NOP;
        q_cmd.ch    = byte_in;
        q_cmd.arg_a = '0;
        q_cmd.arg_b = '0;
        if (!esc_reg)
        begin
            unique case (byte_in)
                CH_NUL: q_cmd.op = OP_NOP;
                CH_ESC: esc_next = 1'b1;
                CH_LF:  q_cmd.op = OP_NEWLINE;
                CH_BS:  q_cmd.op = OP_BACKSPACE;
                default: q_cmd.op = OP_PRINT;
            endcase
        end
        else if (byte_in >= CH_ZERO && byte_in <= CH_NINE)
        begin
            if (second_reg)
            begin
                p2_next   = acc_sat;
                def2_next = 1'b0;
            end
            else
            begin
                p1_next   = acc_sat;
                def1_next = 1'b0;
            end
        end
        else if (byte_in == CH_LBRACK)
        begin
            q_cmd.op = OP_NOP;
        end
        else if (byte_in == CH_SEMI)
        begin
            second_next = 1'b1;
        end
        else
        begin
            esc_next    = 1'b0;
            p1_next     = '0;
            p2_next     = '0;
            second_next = 1'b0;
            def1_next   = 1'b1;
            def2_next   = 1'b1;
            q_cmd.arg_a = move_v;
            unique case (byte_in)
                CH_UP:    q_cmd.op = OP_UP;
                CH_DOWN:  q_cmd.op = OP_DOWN;
                CH_RIGHT: q_cmd.op = OP_RIGHT;
                CH_LEFT:  q_cmd.op = OP_LEFT;
                CH_HOME:
                begin
                    q_cmd.op    = OP_HOME;
                    q_cmd.arg_a = (def1_reg || p1_reg == '0) ? '0 : p1_reg - 16'd1;
                    q_cmd.arg_b = (def2_reg || p2_reg == '0) ? '0 : p2_reg - 16'd1;
                end
                CH_SGR:
                begin
                    q_cmd.op    = OP_SGR;
                    q_cmd.arg_a = p1_reg;
                end
                CH_ED:
                begin
                    q_cmd.op    = OP_ED;
                    q_cmd.arg_a = p1_reg;
                end
                CH_RAW:   q_cmd.op = OP_TOG_RAW;
                CH_NB:    q_cmd.op = OP_TOG_NB;
                CH_NOSCR: q_cmd.op = OP_TOG_SCROLL;
                default:
                begin
                    q_cmd.op = OP_PRINT;
                    q_cmd.ch = CH_QMARK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg    <= 1'b0;
            p1_reg     <= '0;
            p2_reg     <= '0;
            second_reg <= 1'b0;
            def1_reg   <= 1'b1;
            def2_reg   <= 1'b1;
        end
        else if (accept)
        begin
            esc_reg    <= esc_next;
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            second_reg <= second_next;
            def1_reg   <= def1_next;
            def2_reg   <= def2_next;
        end
    end

endmodule

`default_nettype wire

@@ src/atte_cmd_fifo.sv @@
// Short command queue between the parser front end and the display back end.
// Depends on atte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atte_cmd_fifo
    import atte_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t din,
    output logic      full,
    input  wire logic pop,
    output cmd_t      dout,
    output logic      empty
);

    localparam int DEPTH = CMD_FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/atte_back.sv @@
// Back end: executes commands against cursor, colours and mode flags; holds the result register.
// Depends on atte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atte_back
    import atte_pkg::*;
#(
    parameter int MAX_COLS = ATTE_MAX_COLS,
    parameter int MAX_ROWS = ATTE_MAX_ROWS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  cols_cfg,
    input  wire logic [6:0]  rows_cfg,
    input  wire logic        q_empty,
    input  wire cmd_t        q_cmd,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             write_valid,
    output logic [6:0]       write_col,
    output logic [5:0]       write_row,
    output logic [7:0]       write_char,
    output logic [23:0]      text_fg,
    output logic [23:0]      text_bg,
    output logic             scroll_up,
    output logic             clear_screen,
    output logic [6:0]       cursor_col,
    output logic [5:0]       cursor_row,
    output logic             raw_mode,
    output logic             nonblocking_mode
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam logic [8:0] MAX_COLS_W = 9'(MAX_COLS);
    localparam logic [8:0] MAX_ROWS_W = 9'(MAX_ROWS);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [23:0]      fg_reg, fg_next;
    logic [23:0]      bg_reg, bg_next;
    logic             noscr_reg, noscr_next;
    logic             raw_reg, raw_next;
    logic             nb_reg, nb_next;

    logic             out_valid_reg;
    logic             o_wv_reg;
    logic [6:0]       o_wc_reg;
    logic [5:0]       o_wr_reg;
    logic [7:0]       o_ch_reg;
    logic             o_scroll_reg;
    logic             o_clear_reg;

    logic [8:0]       last_col_w;
    logic [8:0]       last_row_w;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             wv;
    logic [COL_W-1:0] wc;
    logic [ROW_W-1:0] wr;
    logic [7:0]       wch;
    logic             scroll;
    logic             clear;
    logic [16:0]      row_sum;
    logic [16:0]      col_sum;
    logic [15:0]      fg_idx;
    logic [15:0]      bg_idx;

    assign last_col_w = (cols_cfg == '0) ? '0 :
                        (9'(cols_cfg) > MAX_COLS_W) ? MAX_COLS_W - 9'd1 : 9'(cols_cfg) - 9'd1;
    assign last_row_w = (rows_cfg == '0) ? '0 :
                        (9'(rows_cfg) > MAX_ROWS_W) ? MAX_ROWS_W - 9'd1 : 9'(rows_cfg) - 9'd1;
    assign last_col   = last_col_w[COL_W-1:0];
    assign last_row   = last_row_w[ROW_W-1:0];

    assign col = (col_reg > last_col) ? last_col : col_reg;
    assign row = (row_reg > last_row) ? last_row : row_reg;

    assign row_sum = {1'b0, q_cmd.arg_a} + 17'(row);
    assign col_sum = {1'b0, q_cmd.arg_a} + 17'(col);
    assign fg_idx  = q_cmd.arg_a - FG_BASE;
    assign bg_idx  = q_cmd.arg_a - BG_BASE;

    assign q_pop = !q_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        col_next   = col;
        row_next   = row;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        noscr_next = noscr_reg;
        raw_next   = raw_reg;
        nb_next    = nb_reg;
        wv         = 1'b0;
        wc         = col;
        wr         = row;
        wch        = q_cmd.ch;
        scroll     = 1'b0;
        clear      = 1'b0;
        unique case (q_cmd.op)
            OP_PRINT:
            begin
                wv = 1'b1;
                if (col == last_col)
                begin
                    col_next = '0;
                    if (row == last_row)
                    begin
                        scroll = !noscr_reg;
                    end
                    else
                    begin
                        row_next = row + 1'b1;
                    end
                end
                else
                begin
                    col_next = col + 1'b1;
                end
            end
            OP_NEWLINE:
            begin
                col_next = '0;
                if (row == last_row)
                begin
                    scroll = 1'b1;
                end
                else
                begin
                    row_next = row + 1'b1;
                end
            end
            OP_BACKSPACE:
            begin
                if (col != '0 || row != '0)
                begin
                    wv  = 1'b1;
                    wch = CH_SPACE;
                    if (col != '0)
                    begin
                        col_next = col - 1'b1;
                        wc       = col - 1'b1;
                    end
                    else
                    begin
                        row_next = row - 1'b1;
                        col_next = last_col;
                        wr       = row - 1'b1;
                        wc       = last_col;
                    end
                end
            end
            OP_UP:
            begin
                row_next = (q_cmd.arg_a > 16'(row)) ? '0 : row - q_cmd.arg_a[ROW_W-1:0];
            end
            OP_DOWN:
            begin
                row_next = (row_sum > 17'(last_row)) ? last_row : row_sum[ROW_W-1:0];
            end
            OP_RIGHT:
            begin
                col_next = (col_sum > 17'(last_col)) ? last_col : col_sum[COL_W-1:0];
            end
            OP_LEFT:
            begin
                col_next = (q_cmd.arg_a > 16'(col)) ? '0 : col - q_cmd.arg_a[COL_W-1:0];
            end
            OP_HOME:
            begin
                row_next = (q_cmd.arg_a > 16'(last_row)) ? last_row : q_cmd.arg_a[ROW_W-1:0];
                col_next = (q_cmd.arg_b > 16'(last_col)) ? last_col : q_cmd.arg_b[COL_W-1:0];
            end
            OP_SGR:
            begin
                if (q_cmd.arg_a >= FG_BASE && fg_idx <= PAL_LAST)
                begin
                    fg_next = PALETTE[fg_idx[2:0]];
                end
                else if (q_cmd.arg_a >= BG_BASE && bg_idx <= PAL_LAST)
                begin
                    bg_next = PALETTE[bg_idx[2:0]];
                end
            end
            OP_ED:         clear      = (q_cmd.arg_a == ED_ALL);
            OP_TOG_RAW:    raw_next   = !raw_reg;
            OP_TOG_NB:     nb_next    = !nb_reg;
            OP_TOG_SCROLL: noscr_next = !noscr_reg;
            default:
            begin
                wv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
            noscr_reg     <= 1'b0;
            raw_reg       <= 1'b0;
            nb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                fg_reg    <= fg_next;
                bg_reg    <= bg_next;
                noscr_reg <= noscr_next;
                raw_reg   <= raw_next;
                nb_reg    <= nb_next;
            end
            out_valid_reg <= q_pop || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            o_wv_reg     <= wv;
            o_wc_reg     <= wv ? 7'(wc) : '0;
            o_wr_reg     <= wv ? 6'(wr) : '0;
            o_ch_reg     <= wv ? wch : '0;
            o_scroll_reg <= scroll;
            o_clear_reg  <= clear;
        end
    end

    assign out_valid        = out_valid_reg;
    assign write_valid      = o_wv_reg;
    assign write_col        = o_wc_reg;
    assign write_row        = o_wr_reg;
    assign write_char       = o_ch_reg;
    assign text_fg          = fg_reg;
    assign text_bg          = bg_reg;
    assign scroll_up        = o_scroll_reg;
    assign clear_screen     = o_clear_reg;
    assign cursor_col       = 7'(col_reg);
    assign cursor_row       = 6'(row_reg);
    assign raw_mode         = raw_reg;
    assign nonblocking_mode = nb_reg;

endmodule

`default_nettype wire

@@ src/ansi_text_terminal_engine_core.sv @@
// Each byte goes through the command queue into the result register that drives out_valid.
// Throughput: one byte per cycle while out_ready is high and the command queue has room.
// A two-entry command queue decouples the parser from the display back end.
// Reset (rst_n low, async): cursor home, parser idle, colours grey on black, flags clear,
// columns_in_use 80, rows_in_use 25. Depends on atte_pkg, atte_front, atte_cmd_fifo, atte_back.
`timescale 1ns / 1ps
`default_nettype none

module ansi_text_terminal_engine_core
    import atte_pkg::*;
#(
    parameter int MAX_COLS = ATTE_MAX_COLS,
    parameter int MAX_ROWS = ATTE_MAX_ROWS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             write_valid,
    output logic [6:0]       write_col,
    output logic [5:0]       write_row,
    output logic [7:0]       write_char,
    output logic [23:0]      text_fg,
    output logic [23:0]      text_bg,
    output logic             scroll_up,
    output logic             clear_screen,
    output logic [6:0]       cursor_col,
    output logic [5:0]       cursor_row,
    output logic             raw_mode,
    output logic             nonblocking_mode
);

    logic [7:0] cols_reg;
    logic [6:0] rows_reg;
    logic       cfg_wr;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    cmd_t       push_cmd;
    cmd_t       head_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_COLS: cols_reg <= pwdata[7:0];
                REG_ROWS: rows_reg <= pwdata[6:0];
                default:  cols_reg <= cols_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_COLS: prdata = {24'd0, cols_reg};
            REG_ROWS: prdata = {25'd0, rows_reg};
            default:  prdata = '0;
        endcase
    end

    atte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .byte_in  (byte_in),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    atte_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (push_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (head_cmd),
        .empty (q_empty)
    );

    atte_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cols_cfg         (cols_reg),
        .rows_cfg         (rows_reg),
        .q_empty          (q_empty),
        .q_cmd            (head_cmd),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .write_valid      (write_valid),
        .write_col        (write_col),
        .write_row        (write_row),
        .write_char       (write_char),
        .text_fg          (text_fg),
        .text_bg          (text_bg),
        .scroll_up        (scroll_up),
        .clear_screen     (clear_screen),
        .cursor_col       (cursor_col),
        .cursor_row       (cursor_row),
        .raw_mode         (raw_mode),
        .nonblocking_mode (nonblocking_mode)
    );

endmodule

`default_nettype wire

@@ tb/ansi_text_terminal_engine_core_test.sv @@
// Self-checking testbench for ansi_text_terminal_engine_core: byte stream in, one display
// command per byte out, checked against a cycle-free terminal predictor kept in this file.
// Depends on atte_pkg and the core RTL only.
`timescale 1ns / 1ps

module ansi_text_terminal_engine_core_test;

    import atte_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int NUM_PHASES      = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_GAP         = 40;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [2:0] ADDR_COLS = {REG_COLS, 2'b00};
    localparam logic [2:0] ADDR_ROWS = {REG_ROWS, 2'b00};

    localparam logic [7:0] CH_BOGUS = 8'h78;

    localparam logic [7:0] ESC_FINALS [10] = '{
        CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_HOME, CH_ED, CH_SGR, CH_RAW, CH_NB, CH_NOSCR
    };

    localparam logic [7:0] PHASE_COLS [NUM_PHASES] = '{
        8'd80, 8'd1, 8'd128, 8'd0, 8'd255, 8'd3, 8'd129, 8'd2, 8'd128, 8'd7
    };
    localparam logic [6:0] PHASE_ROWS [NUM_PHASES] = '{
        7'd25, 7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd65, 7'd64, 7'd1, 7'd5
    };

    typedef struct packed {
        logic        write_valid;
        logic [6:0]  write_col;
        logic [5:0]  write_row;
        logic [7:0]  write_char;
        logic [23:0] text_fg;
        logic [23:0] text_bg;
        logic        scroll_up;
        logic        clear_screen;
        logic [6:0]  cursor_col;
        logic [5:0]  cursor_row;
        logic        raw_mode;
        logic        nonblocking_mode;
    } disp_result_t;

    typedef struct {
        logic [7:0]   b;
        bit           known;
        disp_result_t r;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        write_valid;
    logic [6:0]  write_col;
    logic [5:0]  write_row;
    logic [7:0]  write_char;
    logic [23:0] text_fg;
    logic [23:0] text_bg;
    logic        scroll_up;
    logic        clear_screen;
    logic [6:0]  cursor_col;
    logic [5:0]  cursor_row;
    logic        raw_mode;
    logic        nonblocking_mode;

    // predictor state
    logic [7:0]  win_cols_reg;
    logic [6:0]  win_rows_reg;
    logic [6:0]  term_col;
    logic [5:0]  term_row;
    logic        esc_active;
    logic [15:0] arg_first;
    logic [15:0] arg_second;
    logic        arg_second_on;
    logic        arg_first_dflt;
    logic        arg_second_dflt;
    logic [23:0] fg_now;
    logic [23:0] bg_now;
    logic        scroll_off;
    logic        raw_now;
    logic        nb_now;

    disp_result_t pending_cmds[$];
    int           errors = 0;
    int           cycles = 0;
    int           send_pct = 0;
    int           recv_pct = 0;

    ansi_text_terminal_engine_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .byte_in          (byte_in),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .write_valid      (write_valid),
        .write_col        (write_col),
        .write_row        (write_row),
        .write_char       (write_char),
        .text_fg          (text_fg),
        .text_bg          (text_bg),
        .scroll_up        (scroll_up),
        .clear_screen     (clear_screen),
        .cursor_col       (cursor_col),
        .cursor_row       (cursor_row),
        .raw_mode         (raw_mode),
        .nonblocking_mode (nonblocking_mode)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic disp_result_t screen_cmd(
        input logic wv, input int wc, input int wr, input logic [7:0] wch,
        input logic [23:0] fg, input logic [23:0] bg, input logic scr, input logic clr,
        input int cc, input int cr, input logic raw, input logic nb
    );
        disp_result_t r;
        r.write_valid      = wv;
        r.write_col        = 7'(wc);
        r.write_row        = 6'(wr);
        r.write_char       = wch;
        r.text_fg          = fg;
        r.text_bg          = bg;
        r.scroll_up        = scr;
        r.clear_screen     = clr;
        r.cursor_col       = 7'(cc);
        r.cursor_row       = 6'(cr);
        r.raw_mode         = raw;
        r.nonblocking_mode = nb;
        return r;
    endfunction

    function automatic void place_char(input logic [7:0] ch, input int cols, input int rows,
                                       inout disp_result_t r);
        int col;
        int row;
        r.write_valid = 1'b1;
        r.write_col   = term_col;
        r.write_row   = term_row;
        r.write_char  = ch;
        col = int'(term_col) + 1;
        row = int'(term_row);
        if (col >= cols) begin
            col = 0;
            row++;
        end
        if (row >= rows) begin
            row = rows - 1;
            if (!scroll_off)
                r.scroll_up = 1'b1;
        end
        term_col = 7'(col);
        term_row = 6'(row);
    endfunction

    function automatic disp_result_t advance_terminal(input logic [7:0] b);
        disp_result_t r;
        int cols;
        int rows;
        int v;
        int n;
        int rr;
        int cc;
        r = '0;
        cols = (win_cols_reg == 0) ? 1 : ((win_cols_reg > ATTE_MAX_COLS) ? ATTE_MAX_COLS
                                                                          : int'(win_cols_reg));
        rows = (win_rows_reg == 0) ? 1 : ((win_rows_reg > ATTE_MAX_ROWS) ? ATTE_MAX_ROWS
                                                                          : int'(win_rows_reg));
        if (term_col > cols - 1) term_col = 7'(cols - 1);
        if (term_row > rows - 1) term_row = 6'(rows - 1);

        if (esc_active) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                if (arg_second_on) begin
                    n = int'(arg_second) * 10 + int'(b - CH_ZERO);
                    arg_second = (n > int'(PARAM_MAX)) ? PARAM_MAX : 16'(n);
                    arg_second_dflt = 1'b0;
                end else begin
                    n = int'(arg_first) * 10 + int'(b - CH_ZERO);
                    arg_first = (n > int'(PARAM_MAX)) ? PARAM_MAX : 16'(n);
                    arg_first_dflt = 1'b0;
                end
            end else if (b == CH_SEMI) begin
                arg_second_on = 1'b1;
            end else if (b != CH_LBRACK) begin
                v = arg_first_dflt ? 1 : int'(arg_first);
                case (b)
                    CH_UP: begin
                        if (v > term_row) v = term_row;
                        term_row = 6'(int'(term_row) - v);
                    end
                    CH_DOWN: begin
                        if (int'(term_row) + v > rows - 1) v = rows - 1 - int'(term_row);
                        term_row = 6'(int'(term_row) + v);
                    end
                    CH_RIGHT: begin
                        if (int'(term_col) + v > cols - 1) v = cols - 1 - int'(term_col);
                        term_col = 7'(int'(term_col) + v);
                    end
                    CH_LEFT: begin
                        if (v > term_col) v = term_col;
                        term_col = 7'(int'(term_col) - v);
                    end
                    CH_HOME: begin
                        rr = (arg_first_dflt || arg_first == 0) ? 0 : int'(arg_first) - 1;
                        cc = (arg_second_dflt || arg_second == 0) ? 0 : int'(arg_second) - 1;
                        if (rr >= rows) rr = rows - 1;
                        if (cc >= cols) cc = cols - 1;
                        term_row = 6'(rr);
                        term_col = 7'(cc);
                    end
                    CH_SGR: begin
                        if (arg_first >= FG_BASE && arg_first <= FG_BASE + PAL_LAST)
                            fg_now = PALETTE[arg_first - FG_BASE];
                        else if (arg_first >= BG_BASE && arg_first <= BG_BASE + PAL_LAST)
                            bg_now = PALETTE[arg_first - BG_BASE];
                    end
                    CH_ED: begin
                        if (arg_first == ED_ALL)
                            r.clear_screen = 1'b1;
                    end
                    CH_RAW:   raw_now = ~raw_now;
                    CH_NB:    nb_now = ~nb_now;
                    CH_NOSCR: scroll_off = ~scroll_off;
                    default:  place_char(CH_QMARK, cols, rows, r);
                endcase
                arg_first       = '0;
                arg_second      = '0;
                arg_second_on   = 1'b0;
                arg_first_dflt  = 1'b1;
                arg_second_dflt = 1'b1;
                esc_active      = 1'b0;
            end
        end else begin
            case (b)
                CH_NUL: ;
                CH_ESC: esc_active = 1'b1;
                CH_LF: begin
                    term_col = '0;
                    if (term_row >= rows - 1) begin
                        term_row    = 6'(rows - 1);
                        r.scroll_up = 1'b1;
                    end else begin
                        term_row = term_row + 6'd1;
                    end
                end
                CH_BS: begin
                    if (term_col != 0 || term_row != 0) begin
                        if (term_col != 0) begin
                            term_col = term_col - 7'd1;
                        end else begin
                            term_row = term_row - 6'd1;
                            term_col = 7'(cols - 1);
                        end
                        r.write_valid = 1'b1;
                        r.write_col   = term_col;
                        r.write_row   = term_row;
                        r.write_char  = CH_SPACE;
                    end
                end
                default: place_char(b, cols, rows, r);
            endcase
        end

        r.text_fg          = fg_now;
        r.text_bg          = bg_now;
        r.cursor_col       = term_col;
        r.cursor_row       = term_row;
        r.raw_mode         = raw_now;
        r.nonblocking_mode = nb_now;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit known, input disp_result_t typed);
        disp_result_t pred;
        int gap;
        gap = 0;
        while (send_pct > 0 && $urandom_range(0, 99) < send_pct && gap < MAX_GAP) begin
            in_valid <= 1'b0;
            @(posedge clk);
            gap++;
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do @(posedge clk); while (!in_ready);
        pred = advance_terminal(b);
        pending_cmds.push_back(known ? typed : pred);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_access(input logic [2:0] addr, input bit wr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (!wr && prdata !== data) begin
            $error("register %0d readback: expected %0h, actual %0h", addr, data, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [23:0] exp, input logic [23:0] act);
        if (exp !== act) begin
            $error("%s: expected %0h, actual %0h", name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk) begin : result_check
        disp_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                want = pending_cmds.pop_front();
                check_field("write_valid", want.write_valid, write_valid);
                check_field("write_col", want.write_col, write_col);
                check_field("write_row", want.write_row, write_row);
                check_field("write_char", want.write_char, write_char);
                check_field("text_fg", want.text_fg, text_fg);
                check_field("text_bg", want.text_bg, text_bg);
                check_field("scroll_up", want.scroll_up, scroll_up);
                check_field("clear_screen", want.clear_screen, clear_screen);
                check_field("cursor_col", want.cursor_col, cursor_col);
                check_field("cursor_row", want.cursor_row, cursor_row);
                check_field("raw_mode", want.raw_mode, raw_mode);
                check_field("nonblocking_mode", want.nonblocking_mode, nonblocking_mode);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_pct);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ansi_text_terminal_engine_core_test: FAIL");
            $finish;
        end
    end

    initial begin
        plan_row_t    plan[$];
        logic [7:0]   burst[$];
        logic [23:0]  fg1;
        string        digits;
        int           sent;
        int           k;
        int           v;
        int           nparams;

        win_cols_reg    = COLS_RESET;
        win_rows_reg    = ROWS_RESET;
        term_col        = '0;
        term_row        = '0;
        esc_active      = 1'b0;
        arg_first       = '0;
        arg_second      = '0;
        arg_second_on   = 1'b0;
        arg_first_dflt  = 1'b1;
        arg_second_dflt = 1'b1;
        fg_now          = FG_RESET;
        bg_now          = BG_RESET;
        scroll_off      = 1'b0;
        raw_now         = 1'b0;
        nb_now          = 1'b0;

        fg1 = 24'hAA0000;
        plan.push_back('{8'h41, 1,
            screen_cmd(1, 0, 0, 8'h41, FG_RESET, BG_RESET, 0, 0, 1, 0, 0, 0)});
        plan.push_back('{CH_NUL, 1,
            screen_cmd(0, 0, 0, 8'h00, FG_RESET, BG_RESET, 0, 0, 1, 0, 0, 0)});
        plan.push_back('{CH_BS, 1,
            screen_cmd(1, 0, 0, CH_SPACE, FG_RESET, BG_RESET, 0, 0, 0, 0, 0, 0)});
        // backspace at home does nothing
        plan.push_back('{CH_BS, 1,
            screen_cmd(0, 0, 0, 8'h00, FG_RESET, BG_RESET, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{8'hFF, 1,
            screen_cmd(1, 0, 0, 8'hFF, FG_RESET, BG_RESET, 0, 0, 1, 0, 0, 0)});
        plan.push_back('{CH_LF, 1,
            screen_cmd(0, 0, 0, 8'h00, FG_RESET, BG_RESET, 0, 0, 0, 1, 0, 0)});
        plan.push_back('{CH_ESC, 1,
            screen_cmd(0, 0, 0, 8'h00, FG_RESET, BG_RESET, 0, 0, 0, 1, 0, 0)});
        plan.push_back('{CH_LBRACK, 0, '0});
        plan.push_back('{CH_ZERO + 8'd3, 0, '0});
        plan.push_back('{CH_ZERO + 8'd1, 0, '0});
        plan.push_back('{CH_SGR, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 0, 0, 0, 1, 0, 0)});
        // saturated row parameter clamps to the last row
        plan.push_back('{CH_ESC, 0, '0});
        repeat (5) plan.push_back('{CH_NINE, 0, '0});
        plan.push_back('{CH_HOME, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 0, 0, 0, 24, 0, 0)});
        plan.push_back('{CH_LF, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 1, 0, 0, 24, 0, 0)});
        plan.push_back('{CH_ESC, 0, '0});
        plan.push_back('{CH_ZERO, 0, '0});
        plan.push_back('{CH_HOME, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{CH_ESC, 0, '0});
        plan.push_back('{CH_ZERO + 8'd2, 0, '0});
        plan.push_back('{CH_ED, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 0, 1, 0, 0, 0, 0)});
        plan.push_back('{CH_ESC, 0, '0});
        plan.push_back('{CH_BOGUS, 1,
            screen_cmd(1, 0, 0, CH_QMARK, fg1, BG_RESET, 0, 0, 1, 0, 0, 0)});
        plan.push_back('{CH_ESC, 0, '0});
        plan.push_back('{CH_DOWN, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 0, 0, 1, 1, 0, 0)});
        plan.push_back('{CH_ESC, 0, '0});
        plan.push_back('{CH_LEFT, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 0, 0, 0, 1, 0, 0)});
        plan.push_back('{CH_ESC, 0, '0});
        plan.push_back('{CH_UP, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{CH_ESC, 0, '0});
        plan.push_back('{CH_RIGHT, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 0, 0, 1, 0, 0, 0)});
        plan.push_back('{CH_ESC, 0, '0});
        plan.push_back('{CH_RAW, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 0, 0, 1, 0, 1, 0)});
        plan.push_back('{CH_ESC, 0, '0});
        plan.push_back('{CH_NB, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 0, 0, 1, 0, 1, 1)});
        plan.push_back('{CH_ESC, 0, '0});
        plan.push_back('{CH_NOSCR, 1,
            screen_cmd(0, 0, 0, 8'h00, fg1, BG_RESET, 0, 0, 1, 0, 1, 1)});

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_byte(plan[i].b, plan[i].known, plan[i].r);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            send_pct = 0;
            recv_pct = 0;
            reg_access(ADDR_COLS, 1'b1, {24'b0, PHASE_COLS[p]});
            reg_access(ADDR_ROWS, 1'b1, {25'b0, PHASE_ROWS[p]});
            win_cols_reg = PHASE_COLS[p];
            win_rows_reg = PHASE_ROWS[p];
            reg_access(ADDR_COLS, 1'b0, {24'b0, PHASE_COLS[p]});
            reg_access(ADDR_ROWS, 1'b0, {25'b0, PHASE_ROWS[p]});
            case (p % 4)
                1: send_pct = 78;
                2: recv_pct = 78;
                3: begin
                    send_pct = 38;
                    recv_pct = 38;
                end
                default: ;
            endcase

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                k = $urandom_range(0, 99);
                if (k < 35) begin
                    burst.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                : 8'($urandom_range(32, 126)));
                end else if (k < 45) begin
                    burst.push_back(CH_LF);
                end else if (k < 53) begin
                    burst.push_back(CH_BS);
                end else if (k < 56) begin
                    burst.push_back(CH_NUL);
                end else begin
                    burst.push_back(CH_ESC);
                    if ($urandom_range(0, 9) < 7)
                        burst.push_back(CH_LBRACK);
                    nparams = $urandom_range(0, 2);
                    for (int i = 0; i < nparams; i++) begin
                        if (i == 1)
                            burst.push_back(CH_SEMI);
                        case ($urandom_range(0, 5))
                            0: v = $urandom_range(0, 9);
                            1: v = $urandom_range(0, 70);
                            2: v = $urandom_range(30, 47);
                            3: v = 2;
                            4: v = $urandom_range(0, 999999);
                            default: v = $urandom_range(0, 130);
                        endcase
                        digits = $sformatf("%0d", v);
                        for (int j = 0; j < digits.len(); j++)
                            burst.push_back(digits[j]);
                    end
                    if ($urandom_range(0, 9) < 8)
                        burst.push_back(ESC_FINALS[$urandom_range(0, 9)]);
                    else
                        burst.push_back(8'($urandom_range(0, 255)));
                end

                while (burst.size() != 0 && sent < ITEMS_PER_PHASE) begin
                    send_byte(burst.pop_front(), 0, '0);
                    sent++;
                    if (sent == ITEMS_PER_PHASE / 2)
                        wait_drained();
                end
                burst.delete();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ansi_text_terminal_engine_core_test: PASS");
        else
            $display("ansi_text_terminal_engine_core_test: FAIL");
        $finish;
    end

endmodule

@@ ansi_text_terminal_engine_core.f @@
src/atte_pkg.sv
src/atte_front.sv
src/atte_cmd_fifo.sv
src/atte_back.sv
src/ansi_text_terminal_engine_core.sv
tb/ansi_text_terminal_engine_core_test.sv
